// File: hw/rtl/vlmf_pkg.sv
package vlmf_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 4096;
  localparam int unsigned MAX_READ_DEF    = 64;
  // Must stay a power of two: queue pointers wrap naturally.
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam logic        REG_BUFFER_BYTES = 1'b0;
  localparam logic [12:0] BUFFER_BYTES_RST = 13'd4096;

  typedef enum logic [2:0] {
    CMD_PUSH_BEGIN = 3'd0,
    CMD_PUSH_DATA  = 3'd1,
    CMD_POP        = 3'd2,
    CMD_FRONT      = 3'd3,
    CMD_BACK       = 3'd4,
    CMD_DROP       = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_SIZE       = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_PARAM = 3'd1,
    STS_FULL      = 3'd3,
    STS_EMPTY     = 3'd4,
    STS_TOO_BIG   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_RWAIT,
    ST_RHDR,
    ST_DISP,
    ST_SWAIT,
    ST_STREAM,
    ST_RESULT
  } eng_state_e;

  // Classified input item.
  typedef struct packed {
    cmd_e            cmd;
    logic [7:0]      data;
    logic [15:0]     mlen;
    logic [6:0]      cap;       // already saturated
    logic [1:0]      hdr_last;  // header bytes minus one
    logic [2:0][7:0] hdr;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  out_byte;
    logic [15:0] out_length;
    logic        last;
    logic [12:0] message_count;
    logic [11:0] free_bytes;
  } result_t;

endpackage

// File: hw/rtl/vlmf_queue.sv
module vlmf_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);
  import vlmf_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop)  rd_q <= rd_q + PW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

// File: hw/rtl/vlmf_front.sv
module vlmf_front #(
  parameter int unsigned MAX_READ = vlmf_pkg::MAX_READ_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      command_i,
  input  logic [7:0]      data_byte_i,
  input  logic [15:0]     msg_length_i,
  input  logic [6:0]      read_capacity_i,
  output vlmf_pkg::item_t item_o,
  output logic            item_valid_o,
  input  logic            item_pop_i
);
  import vlmf_pkg::*;

  item_t cls;
  logic  q_empty;

  always_comb begin
    cls      = '0;
    cls.cmd  = cmd_e'(command_i);
    cls.data = data_byte_i;
    cls.mlen = msg_length_i;
    cls.cap  = (32'(read_capacity_i) > MAX_READ) ? 7'(MAX_READ) : read_capacity_i;
    // length header: 1, 2 or 3 bytes, most significant first
    if (msg_length_i < 16'h0040) begin
      cls.hdr[0]   = msg_length_i[7:0];
      cls.hdr_last = 2'd0;
    end else if (msg_length_i < 16'h4000) begin
      cls.hdr[0]   = {2'b01, msg_length_i[13:8]};
      cls.hdr[1]   = msg_length_i[7:0];
      cls.hdr_last = 2'd1;
    end else begin
      cls.hdr[0]   = 8'h80;
      cls.hdr[1]   = msg_length_i[15:8];
      cls.hdr[2]   = msg_length_i[7:0];
      cls.hdr_last = 2'd2;
    end
  end

  vlmf_queue #(.WIDTH($bits(item_t))) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .wdata_i (cls),
    .pop_i   (item_pop_i),
    .empty_o (q_empty),
    .rdata_o (item_o)
  );

  assign item_valid_o = !q_empty;

endmodule

// File: hw/rtl/vlmf_engine.sv
module vlmf_engine #(
  parameter int unsigned STORE_DEPTH = vlmf_pkg::STORE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STORE_DEPTH),
  localparam int unsigned LW = $clog2(STORE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vlmf_pkg::item_t   item_i,
  input  logic              item_valid_i,
  output logic              item_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output vlmf_pkg::result_t res_o,
  input  logic              cfg_clr_i,
  input  logic [LW-1:0]     ring_len_i
);
  import vlmf_pkg::*;

  eng_state_e      state_q, state_d;
  logic [AW-1:0]   wp_q, wp_d, rp_q, rp_d, newest_q, newest_d, pos_q, pos_d;
  logic [15:0]     pbl_q, pbl_d, n_q, n_d, len_q, len_d, mlen_q, mlen_d;
  logic [LW-1:0]   count_q, count_d, skips_q, skips_d;
  logic [1:0]      extra_q, extra_d, hidx_q, hidx_d, hlast_q, hlast_d;
  logic            first_q, first_d;
  cmd_e            cmd_q, cmd_d;
  logic [6:0]      cap_q, cap_d;
  logic [5:0]      idx_q, idx_d;
  status_e         status_q, status_d;
  logic [2:0][7:0] hdr_q, hdr_d;

  logic [7:0]      ring_q [STORE_DEPTH];
  logic [7:0]      rdata_q;
  logic            ring_we;
  logic [7:0]      ring_wdata;

  function automatic logic [AW-1:0] bump(logic [AW-1:0] p, logic [LW-1:0] len);
    logic [LW-1:0] s;
    s = LW'(p) + LW'(1);
    return (s >= len) ? '0 : AW'(s);
  endfunction

  // p + n mod len, with n known below len
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] p, logic [15:0] n,
                                             logic [LW-1:0] len);
    logic [31:0] s;
    s = 32'(p) + 32'(n);
    if (s >= 32'(len)) s = s - 32'(len);
    return AW'(s);
  endfunction

  function automatic logic [31:0] ptr_free(logic [AW-1:0] rp, logic [AW-1:0] wp,
                                           logic [LW-1:0] len);
    if (rp > wp) return 32'(rp) - 32'(wp) - 32'd1;
    return 32'(len) + 32'(rp) - 32'(wp) - 32'd1;
  endfunction

  logic [AW-1:0] wp0;
  logic [31:0]   free0, need, free_now, free_out;
  logic          is_read, is_query, begin_ok, rd_start;
  logic          disp_read, disp_skip, disp_stream, strm_last, hdr_done, rh_done;

  always_comb begin
    wp0       = (pbl_q != '0) ? newest_q : wp_q;
    free0     = ptr_free(rp_q, wp0, ring_len_i);
    need      = 32'(item_i.mlen) + 32'(item_i.hdr_last) + 32'd1;
    is_read   = (item_i.cmd == CMD_POP) || (item_i.cmd == CMD_FRONT) ||
                (item_i.cmd == CMD_BACK);
    is_query  = (item_i.cmd == CMD_DROP) || (item_i.cmd == CMD_SIZE);
    begin_ok  = (item_i.mlen != '0) && (free0 >= need);
    rd_start  = (count_q != '0) && (is_query || (is_read && item_i.cap != '0));
    disp_read = (cmd_q == CMD_POP) || (cmd_q == CMD_FRONT) || (cmd_q == CMD_BACK);
    disp_skip = (cmd_q == CMD_BACK) && (skips_q != '0);
    disp_stream = disp_read && (n_q <= 16'(cap_q)) && (n_q != '0);
    strm_last = (16'(idx_q) + 16'd1 == n_q);
    hdr_done  = (hidx_q == hlast_q);
    rh_done   = first_q ? (rdata_q[7:6] == 2'd0) : (extra_q == 2'd1);
    free_now  = ptr_free(rp_q, wp_q, ring_len_i);
    free_out  = (free_now > 32'(pbl_q)) ? free_now - 32'(pbl_q) : 32'd0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          case (item_i.cmd)
            CMD_PUSH_BEGIN: state_d = begin_ok ? ST_HDR : ST_RESULT;
            CMD_PUSH_DATA,
            CMD_CLEAR:      state_d = ST_RESULT;
            default:        state_d = rd_start ? ST_RWAIT : ST_RESULT;
          endcase
        end
      end
      ST_HDR:    if (hdr_done) state_d = ST_RESULT;
      ST_RWAIT:  state_d = ST_RHDR;
      ST_RHDR:   state_d = rh_done ? ST_DISP : ST_RWAIT;
      ST_DISP: begin
        if (disp_skip) state_d = ST_RWAIT;
        else if (disp_stream) state_d = ST_SWAIT;
        else state_d = ST_RESULT;
      end
      ST_SWAIT:  state_d = ST_STREAM;
      ST_STREAM: if (!res_full_i) state_d = strm_last ? ST_IDLE : ST_SWAIT;
      ST_RESULT: if (!res_full_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && item_valid_i;
    ring_we    = (state_q == ST_HDR) ||
                 (item_pop_o && item_i.cmd == CMD_PUSH_DATA && pbl_q != '0);
    ring_wdata = (state_q == ST_HDR) ? hdr_q[hidx_q] : item_i.data;
    res_push_o = ((state_q == ST_RESULT) || (state_q == ST_STREAM)) && !res_full_i;
    res_o.message_count = 13'(count_q);
    res_o.free_bytes    = free_out[11:0];
    if (state_q == ST_STREAM) begin
      res_o.status     = STS_OK;
      res_o.out_byte   = rdata_q;
      res_o.out_length = n_q;
      res_o.last       = strm_last;
    end else begin
      res_o.status     = status_q;
      res_o.out_byte   = 8'd0;
      res_o.out_length = len_q;
      res_o.last       = 1'b1;
    end
  end

  // datapath
  always_comb begin
    wp_d = wp_q; rp_d = rp_q; newest_d = newest_q; pos_d = pos_q;
    pbl_d = pbl_q; n_d = n_q; len_d = len_q; mlen_d = mlen_q;
    count_d = count_q; skips_d = skips_q; extra_d = extra_q;
    hidx_d = hidx_q; hlast_d = hlast_q; first_d = first_q;
    cmd_d = cmd_q; cap_d = cap_q; idx_d = idx_q; status_d = status_q; hdr_d = hdr_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          cmd_d    = item_i.cmd;
          cap_d    = item_i.cap;
          len_d    = '0;
          status_d = STS_OK;
          case (item_i.cmd)
            CMD_PUSH_BEGIN: begin
              // an unfinished push is abandoned first
              wp_d  = wp0;
              pbl_d = '0;
              if (item_i.mlen == '0) status_d = STS_BAD_PARAM;
              else if (!begin_ok) status_d = STS_FULL;
              else begin
                newest_d = wp0;
                hdr_d    = item_i.hdr;
                hlast_d  = item_i.hdr_last;
                hidx_d   = '0;
                mlen_d   = item_i.mlen;
              end
            end
            CMD_PUSH_DATA: begin
              if (pbl_q == '0) status_d = STS_BAD_PARAM;
              else begin
                wp_d  = bump(wp_q, ring_len_i);
                pbl_d = pbl_q - 16'd1;
                if (pbl_q == 16'd1) count_d = count_q + LW'(1);
              end
            end
            CMD_CLEAR: begin
              wp_d = '0; rp_d = '0; newest_d = '0; pbl_d = '0; count_d = '0;
            end
            default: begin
              if (is_read && item_i.cap == '0) status_d = STS_BAD_PARAM;
              else if (count_q == '0) status_d = STS_EMPTY;
              else begin
                pos_d   = rp_q;
                first_d = 1'b1;
                skips_d = count_q - LW'(1);
              end
            end
          endcase
        end
      end
      ST_HDR: begin
        wp_d   = bump(wp_q, ring_len_i);
        hidx_d = hidx_q + 2'd1;
        if (hdr_done) pbl_d = mlen_q;
      end
      ST_RHDR: begin
        if (first_q) begin
          extra_d = rdata_q[7:6];
          n_d     = {10'd0, rdata_q[5:0]};
        end else begin
          extra_d = extra_q - 2'd1;
          n_d     = {n_q[7:0], rdata_q};
        end
        first_d = 1'b0;
        pos_d   = bump(pos_q, ring_len_i);
      end
      ST_DISP: begin
        if (disp_skip) begin
          pos_d   = wrap_add(pos_q, n_q, ring_len_i);
          skips_d = skips_q - LW'(1);
          first_d = 1'b1;
        end else if (disp_read) begin
          if (n_q > 16'(cap_q)) begin
            status_d = STS_TOO_BIG;
            len_d    = n_q;
          end else if (n_q != '0) begin
            idx_d = '0;
            if (cmd_q == CMD_POP) begin
              rp_d    = wrap_add(pos_q, n_q, ring_len_i);
              count_d = count_q - LW'(1);
            end
          end
        end else begin
          len_d = n_q;
          if (cmd_q == CMD_DROP) begin
            rp_d    = wrap_add(pos_q, n_q, ring_len_i);
            count_d = count_q - LW'(1);
          end
        end
      end
      ST_STREAM: begin
        if (!res_full_i) begin
          pos_d = bump(pos_q, ring_len_i);
          idx_d = idx_q + 6'd1;
        end
      end
      default: ;
    endcase
    if (cfg_clr_i) begin
      wp_d = '0; rp_d = '0; newest_d = '0; pbl_d = '0; count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wp_q     <= '0;
      rp_q     <= '0;
      newest_q <= '0;
      pbl_q    <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      newest_q <= newest_d;
      pbl_q    <= pbl_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    n_q      <= n_d;
    len_q    <= len_d;
    mlen_q   <= mlen_d;
    skips_q  <= skips_d;
    extra_q  <= extra_d;
    hidx_q   <= hidx_d;
    hlast_q  <= hlast_d;
    first_q  <= first_d;
    cmd_q    <= cmd_d;
    cap_q    <= cap_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    hdr_q    <= hdr_d;
  end

  // ring store: read port follows pos_q, and rdata_q holds the addressed byte in the next cycle
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_q[wp_q] <= ring_wdata;
    rdata_q <= ring_q[pos_q];
  end

endmodule

// File: hw/rtl/variable_length_message_fifo.sv
// Variable-length message FIFO on a circular byte store.
// Input channel: push/full with command_i, data_byte_i, msg_length_i and
// read_capacity_i; an item is taken when push is high and full is low.
// Result channel: empty/pop; the oldest result sits on the result ports
// while empty is low and leaves on pop.
// Items go through a two-entry input queue to a sequencer that owns the
// byte ring (one write and one registered read port) and then through a
// two-entry result queue.
// Back walks all stored headers one after another; a read then returns its
// bytes one result at a time.
// A stalled receiver fills the result queue; the sequencer holds and the
// input queue then raises full.
// Reset empties the ring and sets buffer_bytes to 4096. Writing buffer_bytes
// (address 0) also empties the ring; write it only while idle.
module variable_length_message_fifo #(
  parameter int unsigned STORE_DEPTH = vlmf_pkg::STORE_DEPTH_DEF,
  parameter int unsigned MAX_READ    = vlmf_pkg::MAX_READ_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      command_i,
  input  logic [7:0]                      data_byte_i,
  input  logic [15:0]                     msg_length_i,
  input  logic [6:0]                      read_capacity_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      status_o,
  output logic [7:0]                      out_byte_o,
  output logic [15:0]                     out_length_o,
  output logic                            last_o,
  output logic [12:0]                     message_count_o,
  output logic [11:0]                     free_bytes_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vlmf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import vlmf_pkg::*;

  localparam int unsigned LW = $clog2(STORE_DEPTH + 1);

  logic [12:0]   buffer_bytes_q;
  logic [LW-1:0] ring_len;
  logic          cfg_wr;
  item_t         item;
  logic          item_valid, item_pop;
  result_t       res_in, res_out;
  logic          res_full, res_push;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUFFER_BYTES);
  assign prdata = (paddr[2] == REG_BUFFER_BYTES) ? {19'd0, buffer_bytes_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) buffer_bytes_q <= BUFFER_BYTES_RST;
    else if (cfg_wr) buffer_bytes_q <= pwdata[12:0];
  end

  always_comb begin
    if (buffer_bytes_q < 13'd2) ring_len = LW'(2);
    else if (32'(buffer_bytes_q) > STORE_DEPTH) ring_len = LW'(STORE_DEPTH);
    else ring_len = LW'(buffer_bytes_q);
  end

  vlmf_front #(.MAX_READ(MAX_READ)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .data_byte_i     (data_byte_i),
    .msg_length_i    (msg_length_i),
    .read_capacity_i (read_capacity_i),
    .item_o          (item),
    .item_valid_o    (item_valid),
    .item_pop_i      (item_pop)
  );

  vlmf_engine #(.STORE_DEPTH(STORE_DEPTH)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .cfg_clr_i    (cfg_wr),
    .ring_len_i   (ring_len)
  );

  vlmf_queue #(.WIDTH($bits(result_t))) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_out)
  );

  assign status_o        = res_out.status;
  assign out_byte_o      = res_out.out_byte;
  assign out_length_o    = res_out.out_length;
  assign last_o          = res_out.last;
  assign message_count_o = res_out.message_count;
  assign free_bytes_o    = res_out.free_bytes;

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result written into a full queue");

  a_item_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid) else $error("item taken from an empty queue");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push && (res_in.status != STS_OK) |-> res_in.last)
    else $error("error result not marked last");

endmodule
